@@ rtl/tli_pkg.sv @@
package tli_pkg;

  localparam int MaxRows = 64;
  localparam int MaxColumns = 8;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxColumns);
  localparam int AddrW = RowW + ColW;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdLookup = 1'b1;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgColumns = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         row_index;
    logic [2:0]         column_index_in;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         column_index;
    logic signed [31:0] result_value;
    logic               extrapolated;
    logic               divide_fault;
    logic               last;
  } out_item_t;

  // Item passed from the front part to the back part.
  typedef struct packed {
    logic               cmd;
    logic [RowW-1:0]    row;
    logic [ColW-1:0]    col;
    logic               wr_ok;
    logic signed [31:0] data;
    logic [RowW:0]      nr;
    logic [ColW:0]      nc;
  } task_t;

endpackage

@@ rtl/tli_front.sv @@
module tli_front import tli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  output logic  q_valid,
  input  logic  q_pop,
  output task_t q_head
);

  localparam int Depth = 2;

  logic [6:0] rows_r;
  logic [3:0] cols_r;
  task_t      fifo_r [Depth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  task_t      t;
  logic [6:0] nr_c;
  logic [3:0] nc_c;
  logic       push_ok;

  assign cfg_ready = 1'b1;
  assign in_full   = (cnt_r == 2'(Depth));
  assign push_ok   = in_push && !in_full;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_head    = fifo_r[rp_r];

  // Clamp the register values to their legal ranges and classify the item.
  always_comb begin
    nr_c = rows_r;
    if (rows_r < 7'd2) nr_c = 7'd2;
    if (rows_r > 7'(MaxRows)) nr_c = 7'(MaxRows);
    nc_c = cols_r;
    if (cols_r < 4'd2) nc_c = 4'd2;
    if (cols_r > 4'(MaxColumns)) nc_c = 4'(MaxColumns);
    t.cmd   = in_data.cmd;
    t.row   = RowW'(in_data.row_index);
    t.col   = ColW'(in_data.column_index_in);
    t.wr_ok = ({1'b0, in_data.row_index} < 7'(MaxRows)) &&
              ({1'b0, in_data.column_index_in} < 4'(MaxColumns));
    t.data  = (in_data.cmd == CmdWrite) ? in_data.entry_value : in_data.query_x;
    t.nr    = (RowW+1)'(nr_c);
    t.nc    = (ColW+1)'(nc_c);
  end

  // Configuration registers and the task queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd2;
      cols_r <= 4'd2;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CfgRows:    rows_r <= cfg_data;
          CfgColumns: cols_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (push_ok) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) fifo_r[wp_r] <= t;
  end

endmodule

@@ rtl/tli_divider.sv @@
module tli_divider import tli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] q_r;
  logic [33:0] rem_r;
  logic [32:0] d_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [33:0] trial;

  assign trial    = {rem_r[32:0], q_r[63]} - {1'b0, d_r};
  assign quotient = q_r;
  assign done     = busy_r && (cnt_r == 7'd0);

  // Restoring division, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
      q_r    <= dividend;
      rem_r  <= 34'd0;
      d_r    <= divisor;
    end else if (busy_r) begin
      if (cnt_r == 7'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 7'd1;
        if (!trial[33]) begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[32:0], q_r[63]};
          q_r   <= {q_r[62:0], 1'b0};
        end
      end
    end
  end

endmodule

@@ rtl/tli_back.sv @@
module tli_back import tli_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  task_t     q_head,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RDL, S_CMP0, S_SCAN, S_SCANW, S_XRD, S_YRD, S_MUL, S_DSTART,
    S_DIV, S_SUM, S_EMIT, S_HIT, S_HITW
  } state_t;

  state_t state_r;
  logic [31:0] mem_r [MaxRows*MaxColumns];
  logic [AddrW-1:0] raddr;
  logic [31:0] rdata_r;
  task_t tk_r;
  logic signed [31:0] b0_r, x1_r, x2_r, y1_r, y2_r;
  logic [RowW-1:0] lo_r, hi_r, i_r;
  logic [ColW-1:0] j_r;
  logic ext_r, fault_r, neg_r, sel_hi_r;
  logic [63:0] prod_r;
  logic [32:0] dx_mag_r;
  logic [32:0] dy_mag, dq_mag;
  logic signed [32:0] dx, dy, dq;
  logic signed [33:0] sum;
  logic div_start, div_done;
  logic [63:0] quo;
  logic signed [32:0] mq;
  out_item_t ob_r;
  logic ob_full_r;
  logic ob_load;
  logic [ColW:0] jn;
  logic signed [31:0] rs;

  tli_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod_r),
    .divisor(dx_mag_r), .done(div_done), .quotient(quo)
  );

  assign out_empty = !ob_full_r;
  assign out_data  = ob_r;
  assign div_start = (state_r == S_DSTART);
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  // The output register takes a new item when it is free or being emptied.
  assign ob_load = ((state_r == S_SUM) || (state_r == S_HITW) || (state_r == S_EMIT)) &&
                   (!ob_full_r || out_pop);

  // Read address follows the sequencer step.
  always_comb begin
    raddr = '0;
    case (state_r)
      S_IDLE:  raddr = {q_head.row, q_head.col};
      S_RD0:   raddr = '0;
      S_RDL:   raddr = {tk_r.nr[RowW-1:0] - RowW'(1), ColW'(0)};
      S_SCAN:  raddr = {i_r, ColW'(0)};
      S_XRD:   raddr = {lo_r, ColW'(0)};
      S_YRD:   raddr = {hi_r, j_r};
      S_EMIT:  raddr = {lo_r, ColW'(1)};
      S_SUM:   raddr = {lo_r, ColW'(jn)};
      S_HIT:   raddr = {lo_r, j_r};
      default: raddr = {lo_r, j_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.cmd == CmdWrite && q_head.wr_ok)
      mem_r[{q_head.row, q_head.col}] <= q_head.data;
    rdata_r <= mem_r[raddr];
  end

  // Difference terms and saturation of the final sum.
  always_comb begin
    dx = 33'(x2_r) - 33'(x1_r);
    dy = 33'(y2_r) - 33'(y1_r);
    dq = 33'(tk_r.data) - 33'(x1_r);
    dy_mag = dy[32] ? 33'(-dy) : dy;
    dq_mag = dq[32] ? 33'(-dq) : dq;
    mq = (quo > 64'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF : 33'(quo);
    sum = neg_r ? 34'(y1_r) - 34'(mq) : 34'(y1_r) + 34'(mq);
    if (sum > 34'sh0_7FFF_FFFF) rs = 32'sh7FFF_FFFF;
    else if (sum < -34'sh0_8000_0000) rs = 32'sh8000_0000;
    else rs = sum[31:0];
    jn = {1'b0, j_r} + (ColW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ob_full_r <= 1'b0;
    end else begin
      if (ob_load) ob_full_r <= 1'b1;
      else if (out_pop && ob_full_r) ob_full_r <= 1'b0;
      case (state_r)
        S_IDLE: if (q_valid && q_head.cmd == CmdLookup) begin
          tk_r <= q_head; state_r <= S_RD0; ext_r <= 1'b0; fault_r <= 1'b0;
        end
        S_RD0: state_r <= S_RDL;
        S_RDL: begin b0_r <= rdata_r; state_r <= S_CMP0; end
        S_CMP0: begin
          i_r <= '0;
          if (tk_r.data >= b0_r && tk_r.data <= $signed(rdata_r)) state_r <= S_SCAN;
          else begin
            ext_r <= 1'b1; lo_r <= '0; hi_r <= tk_r.nr[RowW-1:0] - RowW'(1);
            state_r <= S_XRD;
          end
        end
        S_SCAN: state_r <= S_SCANW;
        S_SCANW: begin
          if (tk_r.data == $signed(rdata_r)) begin
            lo_r <= i_r; j_r <= '0; state_r <= S_HIT;
          end else if (tk_r.data < $signed(rdata_r) && i_r != '0) begin
            lo_r <= i_r - RowW'(1); hi_r <= i_r; state_r <= S_XRD;
          end else if ({1'b0, i_r} + (RowW+1)'(1) == tk_r.nr) begin
            lo_r <= i_r; j_r <= '0; state_r <= S_HIT;
          end else begin
            i_r <= i_r + RowW'(1); state_r <= S_SCAN;
          end
        end
        // Fetch x1 (lo) then x2 (hi); the lo read is issued from S_XRD.
        S_XRD: begin j_r <= '0; sel_hi_r <= 1'b0; state_r <= S_YRD; end
        // Column 0 collects the breakpoints, other columns collect y1 and y2.
        S_YRD: begin
          if (j_r == '0) begin
            if (!sel_hi_r) begin
              x1_r <= rdata_r; sel_hi_r <= 1'b1;
            end else begin
              x2_r <= rdata_r; state_r <= S_EMIT;
            end
          end else if (!sel_hi_r) begin
            y1_r <= rdata_r; sel_hi_r <= 1'b1;
          end else begin
            y2_r <= rdata_r; state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r   <= 64'(dy_mag) * 64'(dq_mag);
          dx_mag_r <= dx[32] ? 33'(-dx) : dx;
          neg_r    <= (dy[32] != dq[32]) != dx[32];
          if (dx == 33'sd0) fault_r <= 1'b1;
          state_r <= S_DSTART;
        end
        S_DSTART: state_r <= S_DIV;
        S_DIV: if (dx_mag_r == 33'd0 || prod_r == 64'd0) state_r <= S_SUM;
               else if (div_done) state_r <= S_SUM;
        S_SUM: if (ob_load) begin
          ob_r.column_index <= 3'(j_r);
          ob_r.result_value <= (dx_mag_r == 33'd0 || prod_r == 64'd0) ? y1_r : rs;
          ob_r.extrapolated <= ext_r;
          ob_r.divide_fault <= fault_r || dx_mag_r == 33'd0;
          ob_r.last <= (jn == tk_r.nc);
          if (jn == tk_r.nc) state_r <= S_IDLE;
          else begin j_r <= ColW'(jn); sel_hi_r <= 1'b0; state_r <= S_YRD; end
        end
        // Column 0 of an interpolated lookup is the query itself; its fault
        // flag follows from the two breakpoints alone.
        S_EMIT: if (ob_load) begin
          ob_r.column_index <= 3'd0;
          ob_r.result_value <= tk_r.data;
          ob_r.extrapolated <= ext_r;
          ob_r.divide_fault <= (x1_r == x2_r);
          ob_r.last <= 1'b0;
          j_r <= ColW'(1);
          sel_hi_r <= 1'b0;
          state_r <= S_YRD;
        end
        S_HIT: state_r <= S_HITW;
        S_HITW: if (ob_load) begin
          ob_r.column_index <= 3'(j_r);
          ob_r.result_value <= rdata_r;
          ob_r.extrapolated <= 1'b0;
          ob_r.divide_fault <= 1'b0;
          ob_r.last <= (jn == tk_r.nc);
          if (jn == tk_r.nc) state_r <= S_IDLE;
          else begin j_r <= ColW'(jn); state_r <= S_HIT; end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/table_linear_interpolator.sv @@
// Channel | Direction | Handshake
// in_     | input     | push / full, item in in_data
// out_    | output    | pop / empty, item in out_data
// cfg_    | input     | valid / ready, index and data
// Writes land in the table as the sequencer takes them off the queue; a lookup in range
// scans the rows one by one, and each interpolated value column uses the bit-serial divider.
// Reset is synchronous, active low; table contents are unknown until written.
// A full output register stalls the sequencer; a two-entry queue decouples input.
module table_linear_interpolator import tli_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_data,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  logic  q_valid, q_pop;
  task_t q_head;

  tli_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .q_valid, .q_pop, .q_head
  );

  tli_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_head, .out_empty, .out_pop, .out_data
  );

endmodule

@@ dv/tli_result_checker.sv @@
module tli_result_checker import tli_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  in_item_t   in_data,
  input  logic       out_empty,
  input  logic       out_pop,
  input  out_item_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         results_owed
);

  // Private copy of the table and of the two registers.
  logic signed [31:0] table_copy [MaxRows][MaxColumns];
  logic [6:0]         rows_reg;
  logic [3:0]         cols_reg;
  out_item_t          expected_results [$];

  // One point on the line through (x1,y1) and (x2,y2), truncated and saturated.
  function automatic longint line_point(longint x1, longint x2, longint y1,
                                        longint y2, longint x, output bit div_zero);
    longint            dx;
    longint            dy;
    longint            dq;
    longint unsigned   m;
    bit                neg;
    longint            r;
    dx = x2 - x1;
    dy = y2 - y1;
    dq = x - x1;
    div_zero = 1'b0;
    if (dx == 0) begin
      div_zero = 1'b1;
      return y1;
    end
    if (dy == 0 || dq == 0) return y1;
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    m = longint'(dy < 0 ? -dy : dy) * longint'(dq < 0 ? -dq : dq);
    m = m / longint'(dx < 0 ? -dx : dx);
    if (m > 64'h4_0000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
    r = neg ? y1 - longint'(m) : y1 + longint'(m);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // Work out every column result of one lookup and queue them in order.
  task automatic predict_lookup(input logic signed [31:0] query);
    int        nr;
    int        nc;
    int        lo;
    int        hi;
    longint    x;
    longint    b0;
    longint    bl;
    longint    vals [MaxColumns];
    bit        ext;
    bit        fault;
    bit        hit;
    bit        found;
    bit        dz;
    out_item_t res;
    nr = (rows_reg < 2) ? 2 : (rows_reg > MaxRows) ? MaxRows : int'(rows_reg);
    nc = (cols_reg < 2) ? 2 : (cols_reg > MaxColumns) ? MaxColumns : int'(cols_reg);
    x = query;
    b0 = table_copy[0][0];
    bl = table_copy[nr-1][0];
    ext = 1'b0;
    fault = 1'b0;
    hit = 1'b0;
    found = 1'b0;
    lo = 0;
    hi = 0;
    if (x >= b0 && x <= bl) begin
      for (int i = 0; i < nr; i++) begin
        if (!found && x == longint'(table_copy[i][0])) begin
          found = 1'b1;
          hit = 1'b1;
          lo = i;
        end else if (!found && i > 0 && x < longint'(table_copy[i][0])) begin
          found = 1'b1;
          lo = i - 1;
          hi = i;
        end
      end
      if (!found) begin
        hit = 1'b1;
        lo = nr - 1;
      end
    end else begin
      ext = 1'b1;
      hi = nr - 1;
    end
    if (hit) begin
      for (int j = 0; j < nc; j++) vals[j] = table_copy[lo][j];
    end else begin
      vals[0] = x;
      for (int j = 1; j < nc; j++) begin
        vals[j] = line_point(table_copy[lo][0], table_copy[hi][0], table_copy[lo][j],
                             table_copy[hi][j], x, dz);
        fault |= dz;
      end
    end
    for (int j = 0; j < nc; j++) begin
      res.column_index = j[2:0];
      res.result_value = vals[j][31:0];
      res.extrapolated = ext;
      res.divide_fault = fault;
      res.last = (j == nc - 1);
      expected_results.push_back(res);
    end
  endtask

  // Results first, since a result taken in the same cycle as a new item is older.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      foreach (table_copy[r, c]) table_copy[r][c] = '0;
      rows_reg = 7'd2;
      cols_reg = 4'd2;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: column_index %0d value %0d",
                 out_data.column_index, out_data.result_value);
          fail_count++;
        end else begin
          exp_item = expected_results.pop_front();
          if (out_data.column_index !== exp_item.column_index) begin
            $error("column_index: expected %0d, actual %0d",
                   exp_item.column_index, out_data.column_index);
            fail_count++;
          end
          if (out_data.result_value !== exp_item.result_value) begin
            $error("result_value: expected %0d, actual %0d",
                   exp_item.result_value, out_data.result_value);
            fail_count++;
          end
          if (out_data.extrapolated !== exp_item.extrapolated) begin
            $error("extrapolated: expected %0d, actual %0d",
                   exp_item.extrapolated, out_data.extrapolated);
            fail_count++;
          end
          if (out_data.divide_fault !== exp_item.divide_fault) begin
            $error("divide_fault: expected %0d, actual %0d",
                   exp_item.divide_fault, out_data.divide_fault);
            fail_count++;
          end
          if (out_data.last !== exp_item.last) begin
            $error("last: expected %0d, actual %0d", exp_item.last, out_data.last);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgRows) rows_reg = cfg_data;
        else cols_reg = cfg_data[3:0];
      end
      if (in_push && !in_full) begin
        if (in_data.cmd == CmdWrite) begin
          table_copy[in_data.row_index][in_data.column_index_in] = in_data.entry_value;
        end else begin
          predict_lookup(in_data.query_x);
        end
      end
    end
    results_owed = expected_results.size();
  end

endmodule

@@ dv/table_linear_interpolator_tb.sv @@
module table_linear_interpolator_tb;
  import tli_pkg::*;

  localparam int StallLimit = 20000;
  localparam int LongHold = 400;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  in_item_t   in_data;
  logic       out_empty;
  logic       out_pop;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [6:0] cfg_data;
  int         fail_count;
  int         results_owed;
  int         idle_cycles;
  bit         quiet;
  bit         hold_request;
  int         rows_eff;
  int         cols_eff;

  // Stimulus-side copy of the table, used to aim queries at breakpoints.
  logic signed [31:0] shadow [MaxRows][MaxColumns];

  table_linear_interpolator dut (.*);

  tli_result_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any item moving on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: pops with random stall bursts, and one long hold on request.
  initial begin
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_pop <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Offer one item, at times after a random gap, and return once it is taken.
  task automatic send(input in_item_t item);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  task automatic write_entry(input int row, input int col, input logic signed [31:0] value);
    in_item_t   item;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    item = noise[$bits(in_item_t)-1:0];
    item.cmd = CmdWrite;
    item.row_index = row[5:0];
    item.column_index_in = col[2:0];
    item.entry_value = value;
    shadow[row][col] = value;
    send(item);
  endtask

  task automatic lookup(input logic signed [31:0] q);
    in_item_t   item;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    item = noise[$bits(in_item_t)-1:0];
    item.cmd = CmdLookup;
    item.query_x = q;
    send(item);
  endtask

  task automatic drain();
    stop_input();
    while (results_owed != 0) @(negedge clk);
  endtask

  // Register writes only once the block has gone quiet.
  task automatic write_reg(input logic idx, input logic [6:0] value);
    drain();
    repeat (60) @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CfgRows) begin
      rows_eff = (value < 2) ? 2 : (value > MaxRows) ? MaxRows : int'(value);
    end else begin
      cols_eff = (value[3:0] < 2) ? 2 : (value[3:0] > MaxColumns) ? MaxColumns
                 : int'(value[3:0]);
    end
  endtask

  // Fill the rows and columns in use: sorted breakpoints, sometimes
  // with repeats from a narrow window, and now and then out of order.
  task automatic fill_table();
    longint base;
    longint width;
    longint v;
    longint bps [MaxRows];
    longint t;
    int     sel;
    sel = $urandom_range(0, 3);
    width = (sel == 0) ? 8 : (sel == 1) ? 64'd1 << 20 : (sel == 2) ? 64'd1 << 28
            : 64'd1 << 32;
    base = longint'($signed($urandom)) - width / 2;
    for (int i = 0; i < rows_eff; i++) begin
      v = base + longint'({$urandom, $urandom} % width);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      bps[i] = v;
    end
    for (int i = 1; i < rows_eff; i++) begin
      for (int k = i; k > 0 && bps[k-1] > bps[k]; k--) begin
        t = bps[k];
        bps[k] = bps[k-1];
        bps[k-1] = t;
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      t = bps[0];
      bps[0] = bps[rows_eff-1];
      bps[rows_eff-1] = t;
    end
    for (int r = 0; r < rows_eff; r++) begin
      for (int c = 0; c < cols_eff; c++) begin
        if (c == 0) write_entry(r, c, bps[r][31:0]);
        else if ($urandom_range(0, 1) == 0) write_entry(r, c, $urandom);
        else write_entry(r, c, $urandom_range(0, 32'h3_0000) - 32'h1_8000);
      end
    end
  endtask

  // Queries: exact breakpoints, between neighbors, beyond both ends, or anything.
  function automatic logic signed [31:0] pick_query();
    int              i;
    int              k;
    longint          lo;
    longint          hi;
    longint          q;
    longint unsigned span;
    i = $urandom_range(0, rows_eff - 2);
    lo = shadow[i][0];
    hi = shadow[i+1][0];
    k = $urandom_range(0, 9);
    if (k <= 2) begin
      q = shadow[$urandom_range(0, rows_eff - 1)][0];
    end else if (k <= 6) begin
      if (hi > lo) begin
        span = hi - lo;
        q = lo + longint'((longint'($urandom) * span) >> 32);
      end else begin
        q = lo;
      end
    end else if (k == 7) begin
      q = ($urandom_range(0, 3) == 0) ? -64'sd2147483648
          : longint'(shadow[0][0]) - 1 - $urandom_range(0, 1000);
    end else if (k == 8) begin
      q = ($urandom_range(0, 3) == 0) ? 64'sd2147483647
          : longint'(shadow[rows_eff-1][0]) + 1 + $urandom_range(0, 1000);
    end else begin
      q = longint'($signed($urandom));
    end
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic random_items(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) begin
        write_entry($urandom_range(0, MaxRows - 1), $urandom_range(0, MaxColumns - 1),
                    $urandom);
      end else begin
        lookup(pick_query());
      end
    end
  endtask

  int phase_rows [6] = '{3, 9, 0, 5, 2, 2};
  int phase_cols [6] = '{3, 2, 15, 0, 4, 2};
  int phase_len  [6] = '{12, 10, 10, 10, 10, 12};

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgRows;
    cfg_data = '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    rows_eff = 2;
    cols_eff = 2;
    foreach (shadow[r, c]) shadow[r][c] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: full-range breakpoints and values, hits at both ends, interpolation inside.
    write_entry(0, 0, 32'sh8000_0000);
    write_entry(0, 1, 32'sh7fff_ffff);
    write_entry(1, 0, 32'sh7fff_ffff);
    write_entry(1, 1, 32'sh8000_0000);
    lookup(32'sh8000_0000);
    lookup(32'sh7fff_ffff);
    lookup(32'sh0000_0000);
    lookup(32'sh0000_0001);
    // Equal breakpoints: a hit inside, a divide fault outside.
    write_entry(1, 0, 32'sh8000_0000);
    lookup(32'sh8000_0000);
    lookup(32'sh0000_0005);
    // Breakpoints out of order send every query down the outside path.
    write_entry(0, 0, 32'sd100);
    write_entry(1, 0, -32'sd100);
    lookup(32'sd0);
    // Steep line far outside the range saturates both ways.
    write_entry(0, 0, 32'sd0);
    write_entry(1, 0, 32'sd1);
    write_entry(0, 1, 32'sd0);
    write_entry(1, 1, 32'sh7fff_ffff);
    lookup(32'sh7fff_ffff);
    lookup(32'sh8000_0000);
    lookup(-32'sd1);

    // Random phases over several register settings, extremes among them.
    for (int p = 0; p < 6; p++) begin
      write_reg(CfgRows, phase_rows[p][6:0]);
      write_reg(CfgColumns, phase_cols[p][6:0]);
      if (p == 5) quiet = 1'b1;
      fill_table();
      if (p == 0) hold_request = 1'b1;
      random_items(phase_len[p] / 2);
      // Halfway through one phase the sender waits for every result.
      if (p == 2) drain();
      random_items(phase_len[p] - phase_len[p] / 2);
    end

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
